FILE: hdl/gpio_bank_with_irq_detect_macros.svh
// Assertion macros for the GPIO bank with interrupt detection.
// Used by the top level; depends on clk_i and rst_ni being in scope.
`ifndef GPIO_BANK_WITH_IRQ_DETECT_MACROS_SVH
`define GPIO_BANK_WITH_IRQ_DETECT_MACROS_SVH

`ifndef ASSERT_OFF
`define GBID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GBID_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GBID_ASSERT(name, prop, msg)
`define GBID_ASSERT_RST(name, prop, msg)
`endif

`endif

FILE: hdl/gbid_pkg.sv
// Package for the GPIO bank: command and register codes, detect codes, pin mask.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package gbid_pkg;

  localparam int unsigned PIN_COUNT = 32;
  localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DATA     = 3'd0,
    REG_DIR      = 3'd1,
    REG_STATUS   = 3'd2,
    REG_CFG_LO   = 3'd3,
    REG_CFG_HI   = 3'd4,
    REG_MASK     = 3'd5,
    REG_PENDING  = 3'd6,
    REG_BOTH     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DET_LOW     = 2'd0,
    DET_HIGH    = 2'd1,
    DET_RISING  = 2'd2,
    DET_FALLING = 2'd3
  } det_e;

endpackage

FILE: hdl/gbid_if.sv
// Handshake channel interfaces for the GPIO bank: request and response.
// Depends on gbid_pkg.
`timescale 1ns / 1ps

interface gbid_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [2:0]        reg_index;
  gbid_pkg::word_t   write_data;
  gbid_pkg::word_t   pin_levels;

  modport source (output valid, command, reg_index, write_data, pin_levels, input ready);
  modport sink   (input valid, command, reg_index, write_data, pin_levels, output ready);
endinterface

interface gbid_rsp_if;
  logic              valid;
  logic              ready;
  gbid_pkg::word_t   read_data;
  gbid_pkg::word_t   pad_drive;
  gbid_pkg::word_t   pad_enable;
  logic              irq_low;
  logic              irq_high;

  modport source (output valid, read_data, pad_drive, pad_enable, irq_low, irq_high,
                  input ready);
  modport sink   (input valid, read_data, pad_drive, pad_enable, irq_low, irq_high,
                  output ready);
endinterface

FILE: hdl/gpio_bank_with_irq_detect.sv
// Top level of the GPIO bank with per-pin edge and level interrupt detection.
// Depends on gbid_pkg, gbid_if.sv and gpio_bank_with_irq_detect_macros.svh.
`timescale 1ns / 1ps
`include "gpio_bank_with_irq_detect_macros.svh"

// Each request transaction (read, write or pin sample tick) is handled at the
// edge that accepts it: the register file and the response register are both
// loaded then, so the response appears in the following cycle. A new request
// is taken every cycle as long as the response register is empty or being
// drained in the same cycle; the single response register sets that limit.

module gpio_bank_with_irq_detect (
  input  logic           clk_i,
  input  logic           rst_ni,
  gbid_req_if.sink       in_i,
  gbid_rsp_if.source     out_o
);

  gbid_pkg::word_t out_data_q, out_data_d;
  gbid_pkg::word_t dir_q, dir_d;
  // The last sample also serves as the previous sample for edge detection.
  gbid_pkg::word_t status_q, status_d;
  gbid_pkg::word_t cfg_lo_q, cfg_lo_d;
  gbid_pkg::word_t cfg_hi_q, cfg_hi_d;
  gbid_pkg::word_t enable_q, enable_d;
  gbid_pkg::word_t pending_q, pending_d;
  gbid_pkg::word_t both_q, both_d;

  gbid_pkg::word_t rdata_d, rdata_q;
  gbid_pkg::word_t active_d;
  gbid_pkg::word_t hits;
  gbid_pkg::word_t now;
  logic [63:0]     cfg_all;
  logic            out_valid_q;
  logic            irq_low_q, irq_high_q;
  logic            in_acc;
  logic            out_acc;

  assign out_acc  = out_valid_q && out_o.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_all  = {cfg_hi_q, cfg_lo_q};
  assign now      = in_i.pin_levels & gbid_pkg::PIN_MASK;

  always_comb begin
    logic n;
    logic o;
    hits = '0;
    for (int p = 0; p < 32; p++) begin
      n = now[p];
      o = status_q[p];
      if (both_q[p]) begin
        hits[p] = n ^ o;
      end else begin
        case (gbid_pkg::det_e'(cfg_all[2*p +: 2]))
          gbid_pkg::DET_LOW:     hits[p] = !n;
          gbid_pkg::DET_HIGH:    hits[p] = n;
          gbid_pkg::DET_RISING:  hits[p] = n && !o;
          default:               hits[p] = !n && o;
        endcase
      end
    end
  end

  always_comb begin
    out_data_d = out_data_q;
    dir_d      = dir_q;
    status_d   = status_q;
    cfg_lo_d   = cfg_lo_q;
    cfg_hi_d   = cfg_hi_q;
    enable_d   = enable_q;
    pending_d  = pending_q;
    both_d     = both_q;
    rdata_d    = '0;
    case (gbid_pkg::cmd_e'(in_i.command))
      gbid_pkg::CMD_READ: begin
        unique case (gbid_pkg::reg_idx_e'(in_i.reg_index))
          gbid_pkg::REG_DATA:    rdata_d = out_data_q;
          gbid_pkg::REG_DIR:     rdata_d = dir_q;
          gbid_pkg::REG_STATUS:  rdata_d = status_q;
          gbid_pkg::REG_CFG_LO:  rdata_d = cfg_lo_q;
          gbid_pkg::REG_CFG_HI:  rdata_d = cfg_hi_q;
          gbid_pkg::REG_MASK:    rdata_d = enable_q;
          gbid_pkg::REG_PENDING: rdata_d = pending_q;
          gbid_pkg::REG_BOTH:    rdata_d = both_q;
          default:               rdata_d = '0;
        endcase
      end
      gbid_pkg::CMD_WRITE: begin
        unique case (gbid_pkg::reg_idx_e'(in_i.reg_index))
          gbid_pkg::REG_DATA:    out_data_d = in_i.write_data & gbid_pkg::PIN_MASK;
          gbid_pkg::REG_DIR:     dir_d      = in_i.write_data & gbid_pkg::PIN_MASK;
          gbid_pkg::REG_STATUS:  status_d   = status_q;
          gbid_pkg::REG_CFG_LO:  cfg_lo_d   = in_i.write_data;
          gbid_pkg::REG_CFG_HI:  cfg_hi_d   = in_i.write_data;
          gbid_pkg::REG_MASK:    enable_d   = in_i.write_data & gbid_pkg::PIN_MASK;
          gbid_pkg::REG_PENDING: pending_d  = pending_q & ~in_i.write_data;
          gbid_pkg::REG_BOTH:    both_d     = in_i.write_data & gbid_pkg::PIN_MASK;
          default:               both_d     = both_q;
        endcase
      end
      gbid_pkg::CMD_TICK: begin
        pending_d = (pending_q | hits) & gbid_pkg::PIN_MASK;
        status_d  = now;
      end
      default: rdata_d = '0;
    endcase
    active_d = pending_d & enable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
      dir_q      <= '0;
      status_q   <= '0;
      cfg_lo_q   <= '0;
      cfg_hi_q   <= '0;
      enable_q   <= '0;
      pending_q  <= '0;
      both_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        out_data_q <= out_data_d;
        dir_q      <= dir_d;
        status_q   <= status_d;
        cfg_lo_q   <= cfg_lo_d;
        cfg_hi_q   <= cfg_hi_d;
        enable_q   <= enable_d;
        pending_q  <= pending_d;
        both_q     <= both_d;
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q    <= rdata_d;
      irq_low_q  <= |active_d[15:0];
      irq_high_q <= |active_d[31:16];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = rdata_q;
  assign out_o.pad_drive  = out_data_q;
  assign out_o.pad_enable = dir_q;
  assign out_o.irq_low    = irq_low_q;
  assign out_o.irq_high   = irq_high_q;

  `GBID_ASSERT(a_accept_gives_rsp, in_acc |=> out_valid_q, "Accepted request gave no response.")
  `GBID_ASSERT(a_pending_only_on_tick, !(in_acc && in_i.command == gbid_pkg::CMD_TICK) |=> ((pending_q & ~$past(pending_q)) == '0), "Pending bit set without a tick.")
  `GBID_ASSERT(a_irq_matches_state, out_valid_q |-> (irq_low_q == |(pending_q[15:0] & enable_q[15:0])) && (irq_high_q == |(pending_q[31:16] & enable_q[31:16])), "Interrupt lines disagree with state.")
  `GBID_ASSERT_RST(a_no_unused_pins, ((out_data_q | dir_q | enable_q | pending_q | both_q | status_q) & ~gbid_pkg::PIN_MASK) == '0, "Bit set above the pin count.")

endmodule

FILE: tb/tb_gpio_bank_with_irq_detect.sv
// Self-checking testbench for gpio_bank_with_irq_detect: a directed table, then random reads,
// writes, ticks and unused commands, checked against the table or a register-level predictor.
// Depends on gbid_pkg, gbid_if.sv and the RTL top level.
`timescale 1ns / 1ps

module tb_gpio_bank_with_irq_detect;
  import gbid_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam bit KNOWN = 1'b1;
  localparam bit PREDICT = 1'b0;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [1:0] command;
    reg_idx_e   reg_index;
    word_t      write_data;
    word_t      pin_levels;
  } req_t;

  typedef struct packed {
    word_t read_data;
    word_t pad_drive;
    word_t pad_enable;
    logic  irq_low;
    logic  irq_high;
  } resp_t;

  typedef struct packed {
    req_t  stim;
    bit    known;
    resp_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  gbid_req_if req_ch ();
  gbid_rsp_if rsp_ch ();

  gpio_bank_with_irq_detect DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  word_t bank_data;
  word_t bank_dir;
  word_t bank_status;
  word_t bank_prev;
  word_t bank_cfg_lo;
  word_t bank_cfg_hi;
  word_t bank_mask;
  word_t bank_pending;
  word_t bank_both;

  resp_t awaited_resp[$];
  row_t  table_rows[$];
  word_t last_levels;
  int    sent_count;
  int    error_count;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  function automatic bit quiet_stretch();
    return sent_count >= 500 && sent_count < 700;
  endfunction

  function automatic resp_t bank_step(input req_t rq);
    resp_t rsp;
    word_t hits;
    word_t lv;
    word_t active;
    det_e  code;
    logic  cur_lvl;
    logic  old_lvl;
    rsp = '0;
    case (rq.command)
      CMD_READ: begin
        case (rq.reg_index)
          REG_DATA:    rsp.read_data = bank_data;
          REG_DIR:     rsp.read_data = bank_dir;
          REG_STATUS:  rsp.read_data = bank_status;
          REG_CFG_LO:  rsp.read_data = bank_cfg_lo;
          REG_CFG_HI:  rsp.read_data = bank_cfg_hi;
          REG_MASK:    rsp.read_data = bank_mask;
          REG_PENDING: rsp.read_data = bank_pending;
          default:     rsp.read_data = bank_both;
        endcase
      end
      CMD_WRITE: begin
        case (rq.reg_index)
          REG_DATA:    bank_data = rq.write_data & PIN_MASK;
          REG_DIR:     bank_dir = rq.write_data & PIN_MASK;
          REG_STATUS:  ;
          REG_CFG_LO:  bank_cfg_lo = rq.write_data;
          REG_CFG_HI:  bank_cfg_hi = rq.write_data;
          REG_MASK:    bank_mask = rq.write_data & PIN_MASK;
          REG_PENDING: bank_pending = bank_pending & ~rq.write_data;
          default:     bank_both = rq.write_data & PIN_MASK;
        endcase
      end
      CMD_TICK: begin
        lv = rq.pin_levels & PIN_MASK;
        hits = '0;
        for (int p = 0; p < 32; p++) begin
          code = det_e'((p < 16) ? bank_cfg_lo[2*p +: 2] : bank_cfg_hi[2*(p-16) +: 2]);
          cur_lvl = lv[p];
          old_lvl = bank_prev[p];
          if (bank_both[p]) begin
            hits[p] = cur_lvl ^ old_lvl;
          end else begin
            case (code)
              DET_LOW:    hits[p] = !cur_lvl;
              DET_HIGH:   hits[p] = cur_lvl;
              DET_RISING: hits[p] = cur_lvl && !old_lvl;
              default:    hits[p] = !cur_lvl && old_lvl;
            endcase
          end
        end
        bank_pending = (bank_pending | hits) & PIN_MASK;
        bank_status = lv;
        bank_prev = lv;
      end
      default: ;
    endcase
    active = bank_pending & bank_mask;
    rsp.pad_drive = bank_data;
    rsp.pad_enable = bank_dir;
    rsp.irq_low = |active[15:0];
    rsp.irq_high = |active[31:16];
    return rsp;
  endfunction

  function automatic void add_row(input logic [1:0] c, input reg_idx_e r, input word_t wd,
                                  input word_t lv, input bit known, input resp_t want);
    row_t row;
    row.stim = '{command: c, reg_index: r, write_data: wd, pin_levels: lv};
    row.known = known;
    row.want = want;
    table_rows.push_back(row);
  endfunction

  function automatic req_t random_req();
    req_t rq;
    int   pick;
    pick = $urandom_range(99);
    rq.reg_index = reg_idx_e'($urandom_range(7));
    rq.write_data = $urandom();
    rq.pin_levels = $urandom();
    if (pick < 40) begin
      rq.command = CMD_TICK;
      case ($urandom_range(3))
        0: rq.pin_levels = $urandom();
        1: rq.pin_levels = last_levels ^ (32'h1 << $urandom_range(31));
        2: rq.pin_levels = last_levels;
        default: rq.pin_levels = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      last_levels = rq.pin_levels;
    end else if (pick < 70) begin
      rq.command = CMD_WRITE;
      if ($urandom_range(9) == 0) begin
        rq.write_data = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
    end else if (pick < 95) begin
      rq.command = CMD_READ;
    end else begin
      rq.command = CMD_UNUSED;
    end
    return rq;
  endfunction

  task automatic send(input req_t rq, input bit known, input resp_t want);
    resp_t predicted;
    @(negedge clk_i);
    while (!quiet_stretch() && $urandom_range(99) < 35) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= rq.command;
    req_ch.reg_index <= rq.reg_index;
    req_ch.write_data <= rq.write_data;
    req_ch.pin_levels <= rq.pin_levels;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = bank_step(rq);
    awaited_resp.push_back(known ? want : predicted);
    sent_count++;
  endtask

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    rsp_ch.ready <= quiet_stretch() || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin : rsp_monitor
    resp_t got;
    resp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.read_data, rsp_ch.pad_drive, rsp_ch.pad_enable, rsp_ch.irq_low,
             rsp_ch.irq_high};
      if (awaited_resp.size() == 0) begin
        $display("%0t ns: response with none expected, actual %h", $time, got);
        error_count++;
      end else begin
        want = awaited_resp.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("pad_drive", want.pad_drive, got.pad_drive);
        check_field("pad_enable", want.pad_enable, got.pad_enable);
        check_field("irq_low", 32'(want.irq_low), 32'(got.irq_low));
        check_field("irq_high", 32'(want.irq_high), 32'(got.irq_high));
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_READ;
    req_ch.reg_index = REG_DATA;
    req_ch.write_data = '0;
    req_ch.pin_levels = '0;
    rsp_ch.ready = 1'b0;
    bank_data = '0;
    bank_dir = '0;
    bank_status = '0;
    bank_prev = '0;
    bank_cfg_lo = '0;
    bank_cfg_hi = '0;
    bank_mask = '0;
    bank_pending = '0;
    bank_both = '0;
    last_levels = '0;
    sent_count = 0;
    error_count = 0;

    // The first tick compares against an all-zero previous sample; low-level detect is
    // the reset code, so every pin goes pending while the mask still blocks the lines.
    add_row(CMD_READ,   REG_DATA,    32'h0,         32'h0, KNOWN,
            {32'h0, 32'h0, 32'h0, 1'b0, 1'b0});
    add_row(CMD_READ,   REG_PENDING, 32'hFFFF_FFFF, 32'h0, KNOWN,
            {32'h0, 32'h0, 32'h0, 1'b0, 1'b0});
    add_row(CMD_TICK,   REG_DATA,    32'h0,         32'h0, KNOWN,
            {32'h0, 32'h0, 32'h0, 1'b0, 1'b0});
    add_row(CMD_READ,   REG_PENDING, 32'h0,         32'h0, KNOWN,
            {32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b0});
    add_row(CMD_WRITE,  REG_MASK,    32'hFFFF_FFFF, 32'h0, KNOWN,
            {32'h0, 32'h0, 32'h0, 1'b1, 1'b1});
    add_row(CMD_WRITE,  REG_PENDING, 32'h0000_FFFF, 32'h0, KNOWN,
            {32'h0, 32'h0, 32'h0, 1'b0, 1'b1});
    add_row(CMD_WRITE,  REG_DATA,    32'hFFFF_FFFF, 32'h0, KNOWN,
            {32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1});
    add_row(CMD_WRITE,  REG_DIR,     32'hFFFF_FFFF, 32'h0, KNOWN,
            {32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1});
    add_row(CMD_WRITE,  REG_STATUS,  32'hA5A5_A5A5, 32'h0, KNOWN,
            {32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1});
    add_row(CMD_READ,   REG_STATUS,  32'h0,         32'h0, KNOWN,
            {32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1});
    add_row(CMD_WRITE,  REG_CFG_LO,  32'h5555_5555, 32'h0, PREDICT, '0);
    add_row(CMD_WRITE,  REG_CFG_HI,  32'hAAAA_AAAA, 32'h0, PREDICT, '0);
    add_row(CMD_WRITE,  REG_PENDING, 32'hFFFF_FFFF, 32'h0, PREDICT, '0);
    add_row(CMD_TICK,   REG_DATA,    32'h0, 32'hFFFF_FFFF, PREDICT, '0);
    add_row(CMD_WRITE,  REG_PENDING, 32'hFFFF_FFFF, 32'h0, PREDICT, '0);
    add_row(CMD_TICK,   REG_DATA,    32'h0, 32'hFFFF_FFFF, PREDICT, '0);
    add_row(CMD_WRITE,  REG_CFG_LO,  32'hFFFF_FFFF, 32'h0, PREDICT, '0);
    add_row(CMD_WRITE,  REG_BOTH,    32'h00FF_FF00, 32'h0, PREDICT, '0);
    add_row(CMD_WRITE,  REG_PENDING, 32'hFFFF_FFFF, 32'h0, PREDICT, '0);
    add_row(CMD_TICK,   REG_DATA,    32'h0,         32'h0, PREDICT, '0);
    add_row(CMD_READ,   REG_CFG_LO,  32'h0,         32'h0, PREDICT, '0);
    add_row(CMD_READ,   REG_BOTH,    32'h0,         32'h0, PREDICT, '0);
    add_row(CMD_READ,   REG_PENDING, 32'h0,         32'h0, PREDICT, '0);
    add_row(CMD_UNUSED, REG_DATA,    32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICT, '0);
    add_row(CMD_WRITE,  REG_MASK,    32'h0,         32'h0, PREDICT, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (table_rows[i]) begin
      send(table_rows[i].stim, table_rows[i].known, table_rows[i].want);
    end
    repeat (RANDOM_ITEMS) begin
      send(random_req(), PREDICT, '0);
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    while (awaited_resp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #200us;
    $display("simulation failed");
    $finish;
  end

endmodule
